@@ sv/spsv_pkg.sv @@
// ----------------------------------------------------------------------------
// spsv_pkg
// Shared types and constants for the segmented prime sieve.
// ----------------------------------------------------------------------------
package spsv_pkg;

    localparam int DEF_WINDOW_SIZE = 4096;
    localparam int DEF_BASE_DEPTH  = 8192;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_SIEVE  = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] prime_value;
        logic [31:0] window_low;
        logic [12:0] window_length;
    } cmd_t;

    typedef struct packed {
        logic [5:0]  word_index;
        logic [63:0] prime_flags;
        logic        last_word;
    } flag_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] remainder;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_WALK_RD,
        ST_WALK_SQ,
        ST_WALK_CHK,
        ST_WALK_DIV,
        ST_WALK_OFF,
        ST_CLR_RD,
        ST_CLR_WR,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

endpackage

@@ sv/spsv_ram.sv @@
// ----------------------------------------------------------------------------
// spsv_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module spsv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ sv/spsv_div.sv @@
// ----------------------------------------------------------------------------
// spsv_div
// Restoring remainder unit: 32-bit dividend by 16-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module spsv_div (
    input  logic                clk,
    input  logic                rst_n,
    input  spsv_pkg::div_req_t  req,
    output spsv_pkg::div_rsp_t  rsp
);
    import spsv_pkg::*;

    logic [31:0] dvd_reg;
    logic [15:0] dvs_reg;
    logic [15:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [16:0] trial;

    assign trial = {rem_reg, dvd_reg[31]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            // keep the partial remainder below the divisor
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_reg <= 16'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_reg <= trial[15:0];
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;
endmodule

@@ sv/segmented_prime_sieve.sv @@
// ----------------------------------------------------------------------------
// segmented_prime_sieve
// Segmented sieve of Eratosthenes over a window of up to WINDOW_SIZE numbers.
// ----------------------------------------------------------------------------
// Usage: command beats arrive on cmd (valid/ready). Clear empties the base
// prime table, append adds one prime (ignored when the table is full), sieve
// marks a window (length capped at WINDOW_SIZE) and returns ceil(length/64)
// beats on flag, word_index counting up, last_word on the final one. A sieve
// first presets all WORDS words of the window bitmap, then for each base
// prime walked: table read, square and bound check, the single bit-serial
// remainder unit, forming the first multiple, a read-modify-write on the
// bitmap RAM port per multiple cleared and a final bound check. Emission
// reads each word, then offers it and waits out receiver stalls. cmd_ready
// is high only while idle, so one command is worked at a time. When the
// receiver stalls, the current flag beat holds and the sequencer waits.
// Reset clears the sequencer and the prime count; the RAMs need no clearing
// pass, as the count and the preset sweep guard every read.
// ----------------------------------------------------------------------------
module segmented_prime_sieve #(
    parameter int WINDOW_SIZE = spsv_pkg::DEF_WINDOW_SIZE,
    parameter int BASE_DEPTH  = spsv_pkg::DEF_BASE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  spsv_pkg::cmd_t cmd,
    output logic           flag_valid,
    input  logic           flag_ready,
    output spsv_pkg::flag_t flag
);
    import spsv_pkg::*;

    localparam int WORDS = (WINDOW_SIZE + 63) / 64;
    localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int TA    = (BASE_DEPTH > 1) ? $clog2(BASE_DEPTH) : 1;
    localparam int CW    = $clog2(BASE_DEPTH + 1);
    localparam int LW    = $clog2(WINDOW_SIZE + 1);

    state_t state_reg, state_next;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [WA-1:0] w_reg;
    logic [WA-1:0] nlast_reg;
    logic [31:0]   low_reg;
    logic [LW-1:0] len_reg;
    logic [32:0]   end_reg;
    logic [15:0]   p_reg;
    logic [31:0]   sq_reg;
    logic [32:0]   off_reg;

    logic [LW-1:0] len_sat;
    logic [LW-1:0] len_m1;
    logic          cmd_fire;

    logic          tab_we;
    logic [15:0]   tab_rdata;
    logic          bm_we;
    logic [WA-1:0] bm_waddr;
    logic [WA-1:0] bm_raddr;
    logic [63:0]   bm_wdata;
    logic [63:0]   bm_rdata;
    logic [63:0]   init_mask;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [15:0]   m0off;
    logic [32:0]   m0;

    assign cmd_fire = cmd_valid && cmd_ready;
    assign len_sat  = (cmd.window_length > 13'(WINDOW_SIZE)) ? LW'(WINDOW_SIZE)
                                                             : LW'(cmd.window_length);
    assign len_m1   = len_sat - LW'(1);

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && cmd.operation == OP_SIEVE && cmd.window_length != 13'd0)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (w_reg == WA'(WORDS - 1))
                begin
                    state_next = ST_WALK_RD;
                end
            end
            ST_WALK_RD:
            begin
                state_next = (idx_reg >= count_reg) ? ST_EMIT_RD : ST_WALK_SQ;
            end
            ST_WALK_SQ:  state_next = ST_WALK_CHK;
            ST_WALK_CHK:
            begin
                priority if ({1'b0, sq_reg} >= end_reg)
                begin
                    state_next = ST_EMIT_RD;
                end
                else if (p_reg < 16'd2)
                begin
                    state_next = ST_WALK_RD;
                end
                else
                begin
                    state_next = ST_WALK_DIV;
                end
            end
            ST_WALK_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_WALK_OFF;
                end
            end
            ST_WALK_OFF: state_next = ST_CLR_RD;
            ST_CLR_RD:
            begin
                state_next = (off_reg >= 33'(len_reg)) ? ST_WALK_RD : ST_CLR_WR;
            end
            ST_CLR_WR:   state_next = ST_CLR_RD;
            ST_EMIT_RD:  state_next = ST_EMIT_OUT;
            ST_EMIT_OUT:
            begin
                if (flag_ready)
                begin
                    state_next = (w_reg == nlast_reg) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- outputs
    always_comb
    begin
        init_mask = '0;
        for (int b = 0; b < 64; b++)
        begin
            init_mask[b] = (14'({w_reg, 6'(b)}) < 14'(len_reg));
        end
        // 0 and 1 are not prime
        if (w_reg == '0 && low_reg == 32'd0)
        begin
            init_mask[1:0] = 2'b00;
        end
        else if (w_reg == '0 && low_reg == 32'd1)
        begin
            init_mask[0] = 1'b0;
        end
    end

    always_comb
    begin
        cmd_ready  = 1'b0;
        flag_valid = 1'b0;
        tab_we     = 1'b0;
        bm_we      = 1'b0;
        bm_waddr   = w_reg;
        bm_wdata   = init_mask;
        bm_raddr   = w_reg;
        div_req.start    = 1'b0;
        div_req.dividend = low_reg;
        div_req.divisor  = p_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                tab_we    = cmd_valid && cmd.operation == OP_APPEND
                            && count_reg < CW'(BASE_DEPTH);
            end
            ST_INIT:
            begin
                bm_we = 1'b1;
            end
            ST_WALK_CHK:
            begin
                div_req.start = ({1'b0, sq_reg} < end_reg) && (p_reg >= 16'd2);
            end
            ST_CLR_RD:
            begin
                bm_raddr = off_reg[WA+5:6];
            end
            ST_CLR_WR:
            begin
                bm_we    = 1'b1;
                bm_waddr = off_reg[WA+5:6];
                bm_wdata = bm_rdata & ~(64'd1 << off_reg[5:0]);
            end
            ST_EMIT_OUT:
            begin
                flag_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign m0off = (div_rsp.remainder == 16'd0) ? 16'd0 : p_reg - div_rsp.remainder;
    assign m0    = {1'b0, low_reg} + 33'(m0off);

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd_fire && cmd.operation == OP_CLEAR)
            begin
                count_reg <= '0;
            end
            else if (tab_we)
            begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                low_reg   <= cmd.window_low;
                len_reg   <= len_sat;
                end_reg   <= {1'b0, cmd.window_low} + 33'(len_sat);
                nlast_reg <= WA'(len_m1 >> 6);
                w_reg     <= '0;
                idx_reg   <= '0;
            end
            ST_INIT:
            begin
                w_reg <= (w_reg == WA'(WORDS - 1)) ? '0 : w_reg + WA'(1);
            end
            ST_WALK_SQ:
            begin
                p_reg  <= tab_rdata;
                sq_reg <= tab_rdata * tab_rdata;
            end
            ST_WALK_CHK:
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            ST_WALK_OFF:
            begin
                if (m0 < {1'b0, sq_reg})
                begin
                    off_reg <= {1'b0, sq_reg} - {1'b0, low_reg};
                end
                else
                begin
                    off_reg <= 33'(m0off);
                end
            end
            ST_CLR_WR:
            begin
                off_reg <= off_reg + 33'(p_reg);
            end
            ST_EMIT_OUT:
            begin
                if (flag_ready)
                begin
                    w_reg <= w_reg + WA'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    spsv_ram #(.WIDTH(16), .DEPTH(BASE_DEPTH), .AW(TA)) u_table (
        .clk   (clk),
        .we    (tab_we),
        .waddr (count_reg[TA-1:0]),
        .wdata (cmd.prime_value),
        .raddr (idx_reg[TA-1:0]),
        .rdata (tab_rdata)
    );

    spsv_ram #(.WIDTH(64), .DEPTH(WORDS), .AW(WA)) u_bitmap (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    spsv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign flag.word_index  = 6'(w_reg);
    assign flag.prime_flags = bm_rdata;
    assign flag.last_word   = (w_reg == nlast_reg);

    // ---------------------------------------------------------------- checks
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        flag_valid |-> !cmd_ready)
        else $error("flag beat offered while taking commands");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(BASE_DEPTH))
        else $error("base prime count past table depth");

    a_clear_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLR_WR |-> off_reg < 33'(len_reg))
        else $error("clear outside the window");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> state_reg == ST_WALK_DIV)
        else $error("remainder unit started outside the walk");
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for segmented_prime_sieve. Commands load and clear the
// base prime table and sieve windows; a scoreboard sieves each window on its
// own and compares every flag word returned, under random idling on both
// channels.
// ----------------------------------------------------------------------------
module tb;
    import spsv_pkg::*;

    localparam int WIN     = DEF_WINDOW_SIZE;
    localparam int DEPTH   = DEF_BASE_DEPTH;
    localparam int LIMIT   = 3000000;
    localparam int HOLD    = 3000;
    localparam int N_RAND  = 70;

    localparam logic [1:0] OP_SPARE = 2'd3;

    class sieve_board;
        bit [15:0]   base_tbl [DEPTH];
        int unsigned base_cnt;
        logic [63:0] win_bits [64];
        flag_t       words_due [$];
        int          errors;

        function new();
            base_cnt = 0;
            errors   = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void drop_bit(longint unsigned pos);
            if (pos < WIN)
                win_bits[pos >> 6][pos & 63] = 1'b0;
        endfunction

        // work out the flag words one command leaves behind
        function void note(cmd_t c);
            longint unsigned lo, len, fin, p, sq, m, first, v;
            int nw;
            flag_t f;
            case (c.operation)
                OP_CLEAR:  base_cnt = 0;
                OP_APPEND:
                begin
                    if (base_cnt < DEPTH)
                    begin
                        base_tbl[base_cnt] = c.prime_value;
                        base_cnt++;
                    end
                end
                OP_SIEVE:
                begin
                    lo  = c.window_low;
                    len = c.window_length;
                    if (len == 0)
                        return;
                    if (len > WIN)
                        len = WIN;
                    fin = lo + len;
                    nw  = int'((len + 63) / 64);
                    for (int w = 0; w < 64; w++)
                    begin
                        first = w * 64;
                        if (first >= len)
                            win_bits[w] = '0;
                        else if (len - first >= 64)
                            win_bits[w] = '1;
                        else
                            win_bits[w] = (64'd1 << (len - first)) - 64'd1;
                    end
                    for (v = lo; v < 2 && v < fin; v++)
                        drop_bit(v - lo);
                    for (int i = 0; i < base_cnt; i++)
                    begin
                        p  = base_tbl[i];
                        sq = p * p;
                        if (sq >= fin)
                            break;
                        if (p < 2)
                            continue;
                        m = (lo + p - 1) / p * p;
                        if (m < sq)
                            m = sq;
                        for (; m < fin; m += p)
                            drop_bit(m - lo);
                    end
                    for (int w = 0; w < nw; w++)
                    begin
                        f.word_index  = w[5:0];
                        f.prime_flags = win_bits[w];
                        f.last_word   = (w + 1 == nw);
                        words_due.push_back(f);
                    end
                end
                default: ;
            endcase
        endfunction

        task check(flag_t got);
            flag_t want;
            if (words_due.size() == 0)
            begin
                report($sformatf("unexpected word idx=%0d", got.word_index));
                return;
            end
            want = words_due.pop_front();
            if (got.word_index !== want.word_index)
                report($sformatf("word_index %0d, want %0d", got.word_index,
                                 want.word_index));
            if (got.prime_flags !== want.prime_flags)
                report($sformatf("idx %0d prime_flags %h, want %h", want.word_index,
                                 got.prime_flags, want.prime_flags));
            if (got.last_word !== want.last_word)
                report($sformatf("idx %0d last_word %b, want %b", want.word_index,
                                 got.last_word, want.last_word));
        endtask
    endclass

    logic  clk;
    logic  rst_n;
    logic  cmd_valid;
    logic  cmd_ready;
    cmd_t  cmd;
    logic  flag_valid;
    logic  flag_ready;
    flag_t flag;

    sieve_board board;
    bit  calm;
    bit  hold_go;
    bit  held;
    int  cycles;

    segmented_prime_sieve dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .flag_valid (flag_valid),
        .flag_ready (flag_ready),
        .flag       (flag)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** segmented_prime_sieve: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && flag_valid && flag_ready)
            board.check(flag);

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        flag_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_go && !held)
            begin
                held = 1'b1;
                flag_ready <= 1'b0;
                repeat (HOLD) @(posedge clk);
            end
            else
                flag_ready <= calm || ($urandom_range(99) >= 24);
        end
    end

    task send_cmd(logic [1:0] op, logic [15:0] pv, logic [31:0] lo, logic [12:0] len);
        cmd_t c;
        int gap;
        c.operation     = op;
        c.prime_value   = pv;
        c.window_low    = lo;
        c.window_length = len;
        gap = (!calm && $urandom_range(99) < 24) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (!cmd_ready);
        board.note(c);
    endtask

    task send_sieve(logic [31:0] lo, logic [12:0] len);
        send_cmd(OP_SIEVE, 16'($urandom_range(65535)), lo, len);
    endtask

    task send_append(logic [15:0] pv);
        send_cmd(OP_APPEND, pv, 32'($urandom), 13'($urandom_range(8191)));
    endtask

    task drain();
        cmd_valid <= 1'b0;
        while (board.words_due.size() != 0)
            @(posedge clk);
    endtask

    int small_primes [16] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53};

    initial
    begin
        int n_rand, k, start;
        logic [31:0] lo;
        logic [12:0] len;
        board     = new();
        calm      = 1'b0;
        hold_go   = 1'b0;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, small primes, special cases
        send_sieve(32'd0, 13'd64);
        send_append(16'd2);
        send_append(16'd3);
        send_append(16'd5);
        send_append(16'd7);
        send_sieve(32'd0, 13'd100);
        send_sieve(32'd77, 13'd0);
        send_cmd(OP_SPARE, 16'hFFFF, 32'hFFFF_FFFF, 13'h1FFF);
        send_append(16'd0);
        send_append(16'd1);
        send_append(16'd11);
        send_sieve(32'd100, 13'd50);
        send_sieve(32'd0, 13'd8191);
        send_sieve(32'hFFFF_FFFF, 13'd4096);
        send_sieve(32'hFFFF_FF00, 13'd300);
        send_append(16'd65535);
        send_append(16'd13);
        send_sieve(32'd0, 13'd300);
        send_cmd(OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 13'h1FFF);
        send_sieve(32'd1, 13'd1);

        // hold the receiver while the sender keeps pushing windows
        send_append(16'd2);
        send_append(16'd3);
        hold_go = 1'b1;
        for (int i = 0; i < 4; i++)
            send_sieve(32'($urandom_range(5000)), 13'd256);

        // wait for every outstanding word before going on
        drain();

        // random: short tables of mostly ascending primes, then a few windows
        n_rand = 0;
        while (n_rand < N_RAND)
        begin
            calm = (n_rand >= 30 && n_rand < 50);
            if ($urandom_range(99) < 60)
            begin
                send_cmd(OP_CLEAR, 16'($urandom), 32'($urandom), 13'($urandom));
                n_rand++;
            end
            k     = $urandom_range(1, 10);
            start = $urandom_range(0, 3);
            for (int i = 0; i < k; i++)
            begin
                if ($urandom_range(99) < 80 && start + i < 16)
                    send_append(16'(small_primes[start + i]));
                else
                    send_append(16'($urandom_range(65535)));
                n_rand++;
            end
            k = $urandom_range(1, 4);
            for (int i = 0; i < k; i++)
            begin
                case ($urandom_range(9))
                    0, 1, 2:    lo = 32'($urandom);
                    3:          lo = 32'hFFFF_FFFF - 32'($urandom_range(5000));
                    default:    lo = 32'($urandom_range(2000));
                endcase
                case ($urandom_range(19))
                    0:          len = 13'($urandom_range(4097, 8191));
                    1, 2:       len = 13'($urandom_range(321, 4096));
                    default:    len = 13'($urandom_range(1, 320));
                endcase
                send_sieve(lo, len);
                n_rand++;
            end
            if ($urandom_range(99) < 5)
                send_cmd(OP_SPARE, 16'($urandom), 32'($urandom), 13'($urandom));
        end
        calm = 1'b0;

        drain();
        repeat (200) @(posedge clk);
        foreach (board.words_due[i])
            board.report($sformatf("word idx %0d never returned",
                                   board.words_due[i].word_index));
        if (board.errors == 0)
            $display("** segmented_prime_sieve: PASSED **");
        else
            $display("** segmented_prime_sieve: FAILED **");
        $finish;
    end
endmodule
